### hdl/assert_macros.svh
// Assertion macros shared by the frame decoder modules.
// Depends on nothing; each module that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HTFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed: %m");

// A condition at one edge that forces a consequence at the next edge.
`define HTFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### hdl/htfd_pkg.sv
// Package of the humidity and temperature frame decoder: types, codes,
// conversion constants and the CRC-8 byte step. Depends on nothing.
`default_nettype none

package htfd_pkg;

    // Depth of the queue between the frame front end and the converter.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int TEMP_W    = 15;
    localparam int HUMID_W   = 14;
    localparam int RAW_W     = 16;
    localparam int PROD_T_W  = 31;
    localparam int PROD_H_W  = 30;
    localparam int SUM_W     = 32;

    // Conversion constants in hundredths.
    localparam int T_SCALE  = 17500;
    localparam int T_OFFSET = 4500;
    localparam int H_SCALE  = 12500;
    localparam int H_OFFSET = 600;
    localparam int H_MAX    = 10000;

    // CRC-8 of the sensor family: polynomial 0x31, seed 0xFF, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_CRC = 2'd1,
        ST_BUS = 2'd2
    } t_status;

    // One classified frame handed from the front end to the converter.
    typedef struct packed {
        t_status            status;
        logic [RAW_W-1:0]   raw_t;
        logic [RAW_W-1:0]   raw_h;
    } t_cmd;

    // Queue fill flags seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // One byte through the CRC register, eight shift steps.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/htfd_if.sv
// Stream interfaces of the frame decoder: the byte input and the result output.
// Depends on htfd_pkg for the field widths.
`default_nettype none

// Received bytes with the bus failure flag.
interface htfd_in_if import htfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       bus_fail;

    modport source (output valid, output rx_byte, output bus_fail, input ready);
    modport sink   (input valid, input rx_byte, input bus_fail, output ready);
endinterface

// Decoded readings with status and cache flag.
interface htfd_out_if import htfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temp_centi;
    logic [HUMID_W-1:0]        humid_centi;
    logic [1:0]                status;
    logic                      cache_valid;

    modport source (output valid, output temp_centi, output humid_centi,
                    output status, output cache_valid, input ready);
    modport sink   (input valid, input temp_centi, input humid_centi,
                    input status, input cache_valid, output ready);
endinterface

`default_nettype wire

### hdl/htfd_front.sv
// Front end of the frame decoder: takes bytes, tracks the frame position,
// runs the CRC and pushes one classified frame per result. Uses htfd_pkg.
`default_nettype none
`include "assert_macros.svh"

module htfd_front import htfd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    htfd_in_if.sink        i_in,
    input  wire t_q_flags  i_q_flags,
    output logic           o_push,
    output t_cmd           o_cmd
);

    // Byte positions inside the six-byte frame.
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;

    logic [2:0]        r_pos;
    logic [2:0]        n_pos;
    logic [7:0]        r_crc;
    logic              r_t_ok;
    logic [RAW_W-1:0]  r_raw_t;
    logic [RAW_W-1:0]  r_raw_h;
    logic              w_beat;
    logic [7:0]        w_crc_seed;
    logic [7:0]        w_crc_next;

    // A byte is taken whenever the queue has room for a possible result.
    assign i_in.ready = !i_q_flags.full;
    assign w_beat     = i_in.valid && i_in.ready;

    // The CRC restarts on the high byte of each word.
    assign w_crc_seed = (r_pos == POS_T_HI || r_pos == POS_H_HI) ? CRC_INIT : r_crc;
    assign w_crc_next = crc8_byte(w_crc_seed, i_in.rx_byte);

    // Frame position and queue push.
    always_comb begin
        n_pos        = r_pos;
        o_push       = 1'b0;
        o_cmd.status = ST_OK;
        o_cmd.raw_t  = r_raw_t;
        o_cmd.raw_h  = r_raw_h;
        if (w_beat) begin
            if (i_in.bus_fail) begin
                n_pos        = POS_T_HI;
                o_push       = 1'b1;
                o_cmd.status = ST_BUS;
            end else begin
                case (r_pos)
                    POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO: begin
                        n_pos = r_pos + 3'd1;
                    end
                    default: begin
                        // Sixth byte: humidity CRC, frame complete.
                        n_pos        = POS_T_HI;
                        o_push       = 1'b1;
                        o_cmd.status = (r_t_ok && (r_crc == i_in.rx_byte)) ? ST_OK : ST_CRC;
                    end
                endcase
            end
        end
    end

    // Position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_T_HI;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Held words and running CRC.
    always_ff @(posedge i_clk) begin
        if (w_beat && !i_in.bus_fail) begin
            case (r_pos)
                POS_T_HI: begin
                    r_raw_t[15:8] <= i_in.rx_byte;
                    r_crc         <= w_crc_next;
                end
                POS_T_LO: begin
                    r_raw_t[7:0] <= i_in.rx_byte;
                    r_crc        <= w_crc_next;
                end
                POS_T_CRC: begin
                    r_t_ok <= (r_crc == i_in.rx_byte);
                end
                POS_H_HI: begin
                    r_raw_h[15:8] <= i_in.rx_byte;
                    r_crc         <= w_crc_next;
                end
                POS_H_LO: begin
                    r_raw_h[7:0] <= i_in.rx_byte;
                    r_crc        <= w_crc_next;
                end
                default: begin
                end
            endcase
        end
    end

    // A bus failure always restarts the frame.
    `HTFD_ASSERT_NEXT(a_fail_restart, i_clk, i_rst_n, w_beat && i_in.bus_fail, r_pos == POS_T_HI)

    // A push happens only on a failure or at the last byte of a frame.
    `HTFD_ASSERT(a_push_cause, i_clk, i_rst_n, !o_push || i_in.bus_fail || r_pos > POS_H_LO)

endmodule

`default_nettype wire

### hdl/htfd_queue.sv
// Short queue of classified frames between front end and converter.
// Uses htfd_pkg for the entry type and flags.
`default_nettype none
`include "assert_macros.svh"

module htfd_queue import htfd_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_cmd,
    output t_q_flags   o_flags
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(P_DEPTH - 1);

    t_cmd           r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_flags.full  = (r_count == CW'(P_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign o_cmd         = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `HTFD_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_flags.full))
    `HTFD_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_flags.empty))

endmodule

`default_nettype wire

### hdl/htfd_back.sv
// Back end of the frame decoder: scales the raw words to hundredths, clamps
// humidity and holds the result beat. Uses htfd_pkg.
`default_nettype none
`include "assert_macros.svh"

module htfd_back import htfd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_flags  i_q_flags,
    input  wire t_cmd      i_cmd,
    output logic           o_pop,
    htfd_out_if.source     o_out
);

    logic                  r_s1_vld;
    t_status               r_s1_status;
    logic [PROD_T_W-1:0]   r_p_t;
    logic [PROD_H_W-1:0]   r_p_h;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [TEMP_W-1:0]     r_out_temp;
    logic [HUMID_W-1:0]    r_out_humid;
    logic                  r_cache_flag;
    logic                  w_out_free;
    logic                  w_s1_adv;
    logic [SUM_W-1:0]      w_sum_t;
    logic [SUM_W-1:0]      w_sum_h;
    logic [TEMP_W-1:0]     w_q_t;
    logic [HUMID_W-1:0]    w_q_h;
    logic [HUMID_W-1:0]    w_diff_h;
    logic [TEMP_W-1:0]     w_temp;
    logic [HUMID_W-1:0]    w_humid;
    logic                  w_ok;

    // Pipeline flow: the output register frees stage one, stage one frees the queue.
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign o_pop      = (!r_s1_vld || w_out_free) && !i_q_flags.empty;

    // Stage one: constant products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!r_s1_vld || w_out_free) begin
            r_s1_vld <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_status <= i_cmd.status;
            r_p_t       <= PROD_T_W'(T_SCALE) * PROD_T_W'(i_cmd.raw_t);
            r_p_h       <= PROD_H_W'(H_SCALE) * PROD_H_W'(i_cmd.raw_h);
        end
    end

    // Floor division by 65535: (p + (p >> 16) + 1) >> 16 is exact for these products.
    assign w_sum_t = SUM_W'(r_p_t) + SUM_W'(r_p_t >> 16) + SUM_W'(1);
    assign w_sum_h = SUM_W'(r_p_h) + SUM_W'(r_p_h >> 16) + SUM_W'(1);
    assign w_q_t   = w_sum_t[16 +: TEMP_W];
    assign w_q_h   = w_sum_h[16 +: HUMID_W];

    // Offsets and humidity clamp.
    assign w_diff_h = w_q_h - HUMID_W'(H_OFFSET);
    assign w_temp   = w_q_t - TEMP_W'(T_OFFSET);
    assign w_ok     = (r_s1_status == ST_OK);

    always_comb begin
        if (w_q_h < HUMID_W'(H_OFFSET)) begin
            w_humid = '0;
        end else if (w_diff_h > HUMID_W'(H_MAX)) begin
            w_humid = HUMID_W'(H_MAX);
        end else begin
            w_humid = w_diff_h;
        end
    end

    // Output register; the cache flag is set by a good frame and cleared otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_cache_flag <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (w_s1_adv) begin
                r_cache_flag <= w_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_temp   <= w_ok ? w_temp : '0;
            r_out_humid  <= w_ok ? w_humid : '0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out_status;
    assign o_out.temp_centi  = r_out_temp;
    assign o_out.humid_centi = r_out_humid;
    assign o_out.cache_valid = r_cache_flag;

    // A failed frame carries zero readings and an empty cache.
    `HTFD_ASSERT(a_bad_zero, i_clk, i_rst_n, !(r_out_vld && r_out_status != ST_OK) || (r_out_temp == '0 && r_out_humid == '0 && !r_cache_flag))

    // A good frame fills the cache and stays inside the humidity range.
    `HTFD_ASSERT(a_good_range, i_clk, i_rst_n, !(r_out_vld && r_out_status == ST_OK) || (r_cache_flag && r_out_humid <= HUMID_W'(H_MAX)))

endmodule

`default_nettype wire

### hdl/humidity_temp_frame_decoder.sv
// Decodes six-byte humidity/temperature responses: bytes in, one checked and
// scaled reading out per frame or bus failure. One byte is accepted per clock
// while the result queue has room. The queue is written at the edge that
// accepts the sixth byte or the failing beat; the result then passes the
// product stage and the output register. Bytes keep flowing while a result
// waits: input ready drops only when the result queue (P_QUEUE_DEPTH entries)
// fills behind a stalled output. Results whose CRC fails report status 1 and
// zeros, bus failures status 2 and zeros.
// Depends on htfd_pkg, htfd_if, htfd_front, htfd_queue and htfd_back.
`default_nettype none

module humidity_temp_frame_decoder import htfd_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    htfd_in_if.sink     i_in,
    htfd_out_if.source  o_out
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_pop_cmd;
    t_q_flags  w_q_flags;

    // Frame tracking and CRC classification.
    htfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_flags (w_q_flags),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // Queue between the two halves.
    htfd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_flags (w_q_flags)
    );

    // Scaling, clamping and result hold.
    htfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_flags (w_q_flags),
        .i_cmd     (w_pop_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench of the humidity and temperature frame decoder.
// Sends byte beats and bus failures, predicts each reading and checks it.
// Depends on htfd_pkg, htfd_if and humidity_temp_frame_decoder.

module tb_top import htfd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1100;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 800_000;

    // One decoded reading as it leaves the block.
    typedef struct {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [HUMID_W-1:0]       humid_centi;
        t_status                  status;
        logic                     cache_valid;
    } t_reading;

    // Frame tracker of the decoder with the readings it still owes.
    class reading_scoreboard;
        bit [2:0] frame_pos;
        bit [7:0] held_bytes [5];
        bit       cache_ok;
        t_reading pending_readings [$];
        int       mismatches;

        // CRC-8 of one word, bit-serial, MSB first.
        static function bit [7:0] word_crc(bit [15:0] word);
            bit [7:0] crc;
            bit       fb;
            crc = 8'hFF;
            for (int i = 15; i >= 0; i--) begin
                fb  = crc[7] ^ word[i];
                crc = {crc[6:0], 1'b0};
                if (fb) begin
                    crc = crc ^ 8'h31;
                end
            end
            return crc;
        endfunction

        function void add_reading(int t, int h, t_status st);
            t_reading r;
            r.temp_centi  = t[TEMP_W-1:0];
            r.humid_centi = h[HUMID_W-1:0];
            r.status      = st;
            r.cache_valid = cache_ok;
            pending_readings.push_back(r);
        endfunction

        // Takes one accepted input beat and works out the reading it causes.
        function void note_byte(bit [7:0] rx, bit fail);
            bit [15:0] raw_t;
            bit [15:0] raw_h;
            int        t;
            int        h;
            if (fail) begin
                frame_pos = 0;
                cache_ok  = 1'b0;
                add_reading(0, 0, ST_BUS);
            end else if (frame_pos < 5) begin
                held_bytes[frame_pos] = rx;
                frame_pos++;
            end else begin
                frame_pos = 0;
                raw_t = {held_bytes[0], held_bytes[1]};
                raw_h = {held_bytes[3], held_bytes[4]};
                if (word_crc(raw_t) != held_bytes[2] || word_crc(raw_h) != rx) begin
                    cache_ok = 1'b0;
                    add_reading(0, 0, ST_CRC);
                end else begin
                    // Scale to hundredths with floor division, then clamp humidity.
                    t = -4500 + int'((longint'(raw_t) * 17500) / 65535);
                    h = -600 + int'((longint'(raw_h) * 12500) / 65535);
                    if (h < 0) begin
                        h = 0;
                    end
                    if (h > 10000) begin
                        h = 10000;
                    end
                    cache_ok = 1'b1;
                    add_reading(t, h, ST_OK);
                end
            end
        endfunction

        // Compares one accepted reading with the oldest one owed.
        function void check_reading(logic signed [TEMP_W-1:0] t, logic [HUMID_W-1:0] h,
                                    logic [1:0] st, logic cv);
            t_reading want;
            if (pending_readings.size() == 0) begin
                $error("reading with none owed: temp_centi %0d humid_centi %0d status %0d",
                       t, h, st);
                mismatches++;
                return;
            end
            want = pending_readings.pop_front();
            if (t !== want.temp_centi) begin
                $error("temp_centi: expected %0d, got %0d", want.temp_centi, t);
                mismatches++;
            end
            if (h !== want.humid_centi) begin
                $error("humid_centi: expected %0d, got %0d", want.humid_centi, h);
                mismatches++;
            end
            if (st !== 2'(want.status)) begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatches++;
            end
            if (cv !== want.cache_valid) begin
                $error("cache_valid: expected %0d, got %0d", want.cache_valid, cv);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    htfd_in_if  in_if ();
    htfd_out_if out_if ();

    reading_scoreboard readings = new;

    int beats_sent;
    bit send_steady;
    bit long_hold_due;
    bit second_hold_done;

    always #1 i_clk = ~i_clk;

    humidity_temp_frame_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Watch both channels; a beat counts at an edge with valid and ready high.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                readings.note_byte(in_if.rx_byte, in_if.bus_fail);
            end
            if (out_if.valid && out_if.ready) begin
                readings.check_reading(out_if.temp_centi, out_if.humid_centi,
                                       out_if.status, out_if.cache_valid);
            end
        end
    end

    // Idle length shared by both sides: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Raw word picks that favor the ends of the scale and the humidity clamps.
    function automatic bit [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(3140 + $urandom_range(0, 12));
            3: return 16'(55568 + $urandom_range(0, 12));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input bit [7:0] rx, input bit fail);
        int gap;
        gap = send_steady ? 0 : idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.rx_byte  <= rx;
        in_if.bus_fail <= fail;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Six-byte response; a nonzero flip mask corrupts the matching CRC byte.
    task automatic send_frame(input bit [15:0] raw_t, input bit [15:0] raw_h,
                              input bit [7:0] t_flip, input bit [7:0] h_flip);
        send_beat(raw_t[15:8], 1'b0);
        send_beat(raw_t[7:0], 1'b0);
        send_beat(reading_scoreboard::word_crc(raw_t) ^ t_flip, 1'b0);
        send_beat(raw_h[15:8], 1'b0);
        send_beat(raw_h[7:0], 1'b0);
        send_beat(reading_scoreboard::word_crc(raw_h) ^ h_flip, 1'b0);
    endtask

    // A few random bytes, then a bus failure that carries a random byte.
    task automatic abort_frame(input int n);
        repeat (n) send_beat(8'($urandom), 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    // Result side: random stalls, stall-free stretches and long hold-offs.
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 15) == 0) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Reset, directed frames, random traffic, then drain and report.
    initial begin
        int       pick;
        bit [7:0] t_flip;
        bit [7:0] h_flip;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.rx_byte  = 8'h00;
        in_if.bus_fail = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scale ends with both humidity clamps, each CRC corrupted, bus aborts.
        send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00);
        send_frame(16'h6666, 16'h8000, 8'h01, 8'h00);
        send_frame(16'h1234, 16'hABCD, 8'h00, 8'h80);
        abort_frame(2);
        abort_frame(0);

        long_hold_due = 1'b1;
        while (beats_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                send_steady = !send_steady;
            end
            if (!second_hold_done && beats_sent >= ITEM_TARGET / 2) begin
                second_hold_done = 1'b1;
                long_hold_due    = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                t_flip = 8'h00;
                h_flip = 8'h00;
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 2))
                        0: t_flip = 8'($urandom_range(1, 255));
                        1: h_flip = 8'($urandom_range(1, 255));
                        default: begin
                            t_flip = 8'($urandom_range(1, 255));
                            h_flip = 8'($urandom_range(1, 255));
                        end
                    endcase
                end
                send_frame(pick_raw(), pick_raw(), t_flip, h_flip);
            end else if (pick < 85) begin
                abort_frame($urandom_range(0, 5));
            end else begin
                // Stray bytes knock the framing off until the next bus failure.
                repeat ($urandom_range(1, 8)) send_beat(8'($urandom), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(8'($urandom), 1'b1);
                end
            end
        end
        in_if.valid <= 1'b0;

        while (readings.pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (readings.mismatches == 0 && readings.pending_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
